// ===== hw/rtl/ttc_eb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_eb_pkg
// Shared types and constants of the time-to-collision emergency brake.
// ----------------------------------------------------------------------------
package ttc_eb_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ANGLE_START = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_TTC_THRESH  = 2'd2
    } t_cfg_idx;

    // item kinds on the input stream
    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_BEAM  = 1'b1;

    // register reset values
    localparam logic [15:0] ANGLE_START_RST = 16'hB49A;  // -19302
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd287;
    localparam logic [15:0] TTC_THRESH_RST  = 16'd1200;

    localparam int BEAM_INDEX_W = 11;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [15:0] NO_RETURN   = 16'hFFFF;
    localparam int          RANGE_SCALE = 1000;

    // 2^32 / (2*pi) in Q16, angle in rad*65536 to phase in turns
    localparam logic [29:0] TURN_PER_RAD_Q16 = 30'd683565276;

    // cosine table build, evaluated at elaboration only
    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 7;
    localparam int          TAYLOR_DENOM [TAYLOR_TERMS] = '{182, 132, 90, 56, 30, 12, 2};

    // one beam as handed from the front to the back
    typedef struct packed {
        logic [31:0] angle;
        logic [15:0] speed;
        logic [15:0] range_mm;
        logic        last;
        logic        no_return;
    } t_beam;

endpackage

// ===== hw/rtl/ttc_eb_queue.sv =====
// ----------------------------------------------------------------------------
// ttc_eb_queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module ttc_eb_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/ttc_eb_front.sv =====
// ----------------------------------------------------------------------------
// ttc_eb_front
// Accepts speed updates and beams, tracks the scan position and beam angle.
// ----------------------------------------------------------------------------
module ttc_eb_front #(
    parameter  int MAX_BEAMS = 2048,
    localparam int CNT_W     = $clog2(MAX_BEAMS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [31:0]        i_s_axis_tdata,   // speed_mm_s, range_mm
    input  logic               i_s_axis_tuser,   // kind
    input  logic               i_s_axis_tlast,   // last_beam
    input  logic [15:0]        i_angle_start,
    input  logic [15:0]        i_angle_step,
    input  logic               i_q_full,
    output logic               o_push,
    output ttc_eb_pkg::t_beam  o_beam,
    output logic [CNT_W-1:0]   o_index
);
    import ttc_eb_pkg::*;

    logic [15:0]      r_speed;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_acc;
    logic [31:0]      start_scaled;
    logic [31:0]      angle;
    logic             accept;

    assign start_scaled = {{13{i_angle_start[15]}}, i_angle_start, 3'b000};
    // first beam of a scan takes the start angle directly
    assign angle        = (r_cnt == '0) ? start_scaled : r_acc;

    assign o_s_axis_tready = !i_q_full;
    assign accept          = i_s_axis_tvalid && !i_q_full;
    assign o_push          = accept && (i_s_axis_tuser == KIND_BEAM);

    always_comb begin
        o_beam.angle     = angle;
        o_beam.speed     = r_speed;
        o_beam.range_mm  = i_s_axis_tdata[31:16];
        o_beam.last      = i_s_axis_tlast;
        o_beam.no_return = (i_s_axis_tdata[31:16] == NO_RETURN);
    end
    assign o_index = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            if (i_s_axis_tuser == KIND_SPEED) begin
                r_speed <= i_s_axis_tdata[15:0];
            end else if (i_s_axis_tlast) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= (r_cnt == CNT_W'(MAX_BEAMS - 1)) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // only read while the count is non-zero, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_acc <= angle + {16'h0000, i_angle_step};
        end
    end

endmodule

// ===== hw/rtl/ttc_eb_back.sv =====
// ----------------------------------------------------------------------------
// ttc_eb_back
// Beam datapath: phase, cosine lookup, closing speed, time-to-collision test.
// ----------------------------------------------------------------------------
module ttc_eb_back #(
    parameter  int MAX_BEAMS       = 2048,
    parameter  int COS_TABLE_DEPTH = 1024,
    localparam int CNT_W           = $clog2(MAX_BEAMS),
    localparam int IDX_W           = $clog2(COS_TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beam_valid,
    input  ttc_eb_pkg::t_beam  i_beam,
    input  logic [CNT_W-1:0]   i_index,
    output logic               o_pop,
    input  logic [15:0]        i_ttc_thresh,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata    // stop_request, beam_index, zero pad
);
    import ttc_eb_pkg::*;

    localparam int PB_W = 30 + IDX_W + 1;

    typedef logic [15:0] t_cos_rom [COS_TABLE_DEPTH];

    // quarter-wave cosine, Taylor series in Q30 rounded to unsigned Q15
    function automatic logic [15:0] cos_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] m;
        x  = (64'(k) * HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 0; n < TAYLOR_TERMS; n++) begin
            m = ((x2 * t) >> 30) / 64'(TAYLOR_DENOM[n]);
            t = (m <= Q30_ONE) ? Q30_ONE - m : 64'd0;
        end
        t = (t + 64'd16384) >> 15;
        if (t > 64'd32768) begin
            t = 64'd32768;
        end
        return t[15:0];
    endfunction

    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            rom[k] = cos_entry(k);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

    logic en;

    // stage a: phase in turns
    logic             r_a_valid;
    logic [31:0]      r_a_phase;
    t_beam            r_a_beam;
    logic [CNT_W-1:0] r_a_index;
    logic [62:0]      a_prod;

    // stage b: table address
    logic             r_b_valid;
    logic [IDX_W-1:0] r_b_addr;
    logic             r_b_zero;
    logic             r_b_neg;
    t_beam            r_b_beam;
    logic [CNT_W-1:0] r_b_index;
    logic [PB_W-1:0]  b_prod;
    logic [IDX_W-1:0] b_i;
    logic [IDX_W:0]   b_diff;
    logic             b_reflect;

    // stage c: table read
    logic             r_c_valid;
    logic [15:0]      r_c_rom;
    logic             r_c_zero;
    logic             r_c_neg;
    t_beam            r_c_beam;
    logic [CNT_W-1:0] r_c_index;

    // stage d: closing speed
    logic             r_d_valid;
    logic [32:0]      r_d_closing;
    t_beam            r_d_beam;
    logic [CNT_W-1:0] r_d_index;
    logic [16:0]      d_mag;
    logic [16:0]      d_cos;

    // stage e: threshold test
    logic             r_e_valid;
    logic             r_e_hit;
    logic             r_e_last;
    logic [CNT_W-1:0] r_e_index;
    logic [25:0]      e_range_k;
    logic [46:0]      e_lhs;
    logic [46:0]      e_rhs;
    logic             e_pos;

    // result
    logic             r_stopped;
    logic             r_out_valid;
    logic [BEAM_INDEX_W-1:0] r_out_index;
    logic [CNT_W+BEAM_INDEX_W-1:0] idx_ext;
    logic             trig;

    // whole datapath moves when the result register is free
    assign en    = !r_out_valid || i_m_axis_tready;
    assign o_pop = en && i_beam_valid;

    assign a_prod = {{31{i_beam.angle[31]}}, i_beam.angle} * 63'(TURN_PER_RAD_Q16);

    assign b_prod    = PB_W'(r_a_phase[29:0]) * PB_W'(COS_TABLE_DEPTH);
    assign b_i       = b_prod[30 +: IDX_W];
    assign b_reflect = r_a_phase[30];
    assign b_diff    = (IDX_W + 1)'(COS_TABLE_DEPTH) - {1'b0, b_i};

    assign d_mag = r_c_zero ? 17'd0 : {1'b0, r_c_rom};
    assign d_cos = r_c_neg ? 17'd0 - d_mag : d_mag;

    assign e_pos     = !r_d_closing[32] && (r_d_closing != '0);
    assign e_range_k = 26'(r_d_beam.range_mm) * 26'(RANGE_SCALE);
    assign e_lhs     = {6'd0, e_range_k, 15'd0};
    assign e_rhs     = 47'(i_ttc_thresh) * 47'(r_d_closing[30:0]);

    assign trig    = r_e_valid && r_e_hit && !r_stopped;
    assign idx_ext = {{BEAM_INDEX_W{1'b0}}, r_e_index};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_phase   <= a_prod[47:16];
            r_a_beam    <= i_beam;
            r_a_index   <= i_index;

            r_b_addr    <= b_reflect ? b_diff[IDX_W-1:0] : b_i;
            r_b_zero    <= b_reflect && (b_i == '0);
            r_b_neg     <= r_a_phase[31] ^ r_a_phase[30];
            r_b_beam    <= r_a_beam;
            r_b_index   <= r_a_index;

            r_c_rom     <= COS_ROM[r_b_addr];
            r_c_zero    <= r_b_zero;
            r_c_neg     <= r_b_neg;
            r_c_beam    <= r_b_beam;
            r_c_index   <= r_b_index;

            r_d_closing <= {{17{r_c_beam.speed[15]}}, r_c_beam.speed}
                         * {{16{d_cos[16]}}, d_cos};
            r_d_beam    <= r_c_beam;
            r_d_index   <= r_c_index;

            r_e_hit     <= e_pos && !r_d_beam.no_return && (e_lhs < e_rhs);
            r_e_last    <= r_d_beam.last;
            r_e_index   <= r_d_index;

            if (trig) begin
                r_out_index <= idx_ext[BEAM_INDEX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= o_pop;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= trig;
            // one stop per scan, the last beam reopens it
            if (r_e_valid) begin
                r_stopped <= r_e_last ? 1'b0 : (r_stopped || r_e_hit);
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(16 - BEAM_INDEX_W - 1)'(0), r_out_index, 1'b1};

endmodule

// ===== hw/rtl/ttc_emergency_brake_unit.sv =====
// ----------------------------------------------------------------------------
// ttc_emergency_brake_unit
// Time-to-collision emergency brake over a lidar scan and vehicle speed.
// ----------------------------------------------------------------------------
// Speed updates and beam samples arrive on one input stream, one per cycle
// while the queue is not full. The front keeps the speed, the beam count and
// the beam angle and passes each beam through a four-entry queue to the back,
// a five-stage datapath (phase multiply, table index multiply, cosine table
// read, closing speed multiply, threshold multiply and compare) followed by
// the result register. At most one stop request is issued per scan. Output
// back-pressure holds the back; the queue keeps the input open meanwhile
// until it fills.
// ----------------------------------------------------------------------------
module ttc_emergency_brake_unit #(
    parameter int MAX_BEAMS       = 2048,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // [15:0] speed_mm_s, [31:16] range_mm
    input  logic        i_s_axis_tuser,    // kind
    input  logic        i_s_axis_tlast,    // last_beam
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,    // [0] stop_request, [11:1] beam_index, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ttc_eb_pkg::*;

    localparam int CNT_W = $clog2(MAX_BEAMS);
    localparam int REC_W = $bits(t_beam) + CNT_W;

    logic [15:0]      r_angle_start;
    logic [15:0]      r_angle_step;
    logic [15:0]      r_ttc_thresh;

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    t_beam            front_beam;
    logic [CNT_W-1:0] front_index;
    logic [REC_W-1:0] q_out;
    t_beam            back_beam;
    logic [CNT_W-1:0] back_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= ANGLE_START_RST;
            r_angle_step  <= ANGLE_STEP_RST;
            r_ttc_thresh  <= TTC_THRESH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ANGLE_START: r_angle_start <= i_cfg_data;
                CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                CFG_TTC_THRESH:  r_ttc_thresh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ttc_eb_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_angle_start   (r_angle_start),
        .i_angle_step    (r_angle_step),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_beam          (front_beam),
        .o_index         (front_index)
    );

    ttc_eb_queue #(
        .W     (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_index, front_beam}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign back_beam  = q_out[$bits(t_beam)-1:0];
    assign back_index = q_out[REC_W-1:$bits(t_beam)];

    ttc_eb_back #(
        .MAX_BEAMS       (MAX_BEAMS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beam_valid    (!q_empty),
        .i_beam          (back_beam),
        .i_index         (back_index),
        .o_pop           (pop),
        .i_ttc_thresh    (r_ttc_thresh),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== hw/rtl/ttc_eb_checker.sv =====
// ----------------------------------------------------------------------------
// ttc_eb_checker
// Port-level checks of the emergency brake unit, bound to the top level.
// ----------------------------------------------------------------------------
module ttc_eb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // every result is a stop command
    a_stop_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[0])
        else $error("result without stop request bit");

    // padding above the beam index stays clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:12] == 4'h0))
        else $error("result padding not zero");

    // reset empties the result register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    // a stalled transaction keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind ttc_emergency_brake_unit ttc_eb_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
